// ----- src/bpfa_pkg.sv -----
// Shared types and constants for the bitmap page frame allocator.
// No dependencies; bpfa_ctrl, bpfa_dp, the top level and the testbench import this package.
package bpfa_pkg;

	localparam int PAGE_SHIFT  = 12;
	localparam int PAGE_NUM_W  = 32 - PAGE_SHIFT;
	localparam int MAX_REGIONS = 32;
	localparam int REG_IDX_W   = 5;
	localparam int RCNT_W      = 6;
	localparam int CNT_W       = 16;
	localparam int PIDX_W      = 15;
	localparam int WORD_AW     = 10;
	localparam int WORDS       = 1024;
	localparam int BIT_W       = 5;
	localparam logic [CNT_W-1:0]      MAX_PAGES = 16'd32768;
	localparam logic [PAGE_NUM_W-1:0] LOW_PAGE  = 20'd256;
	localparam logic [31:0]           KIMG_RST  = 32'h0010_0000;

	typedef enum logic [2:0] {
		OPC_ADD   = 3'd0,
		OPC_FIN   = 3'd1,
		OPC_ALLOC = 3'd2,
		OPC_MARK  = 3'd3,
		OPC_FREE  = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_REJECT = 2'd1,
		ST_IGNORE = 2'd2
	} status_t;

	typedef enum logic {
		CFG_KSTART = 1'b0,
		CFG_KEND   = 1'b1
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_WALK, OP_ADD_PUT, OP_SPLIT, OP_NUM_INIT, OP_NUM,
		OP_CLEAR, OP_SCAN_RD, OP_SCAN, OP_BIT, OP_MAP, OP_MARK_RD, OP_MARK_WR,
		OP_SET_WR
	} dp_op_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [31:0] region_start;
		logic [31:0] region_end;
		logic [15:0] block_count;
		logic [31:0] page_addr;
	} req_t;

	typedef struct packed {
		dp_op_t  op;
		logic    res_en;
		status_t res_code;
	} dp_cmd_t;

	typedef struct packed {
		opcode_t opc;
		logic    walk_end;
		logic    add_empty;
		logic    overlap;
		logic    full;
		logic    w_zero;
		logic    w_ones;
		logic    hit32;
		logic    word_last;
		logic    bit_hit;
		logic    bit_last;
		logic    map_hit;
		logic    k_ok;
		logic    mark_last;
		logic    same;
		logic    alloc_bad;
		logic    set_bad;
	} dp_stat_t;

endpackage

// ----- src/bpfa_req_if.sv -----
// Request, response and configuration channels of the allocator.
// Depends on nothing; field widths follow the port list.
interface bpfa_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [31:0] region_start;
	logic [31:0] region_end;
	logic [15:0] block_count;
	logic [31:0] page_addr;
	modport source (output valid, opcode, region_start, region_end, block_count, page_addr,
		input ready);
	modport sink (input valid, opcode, region_start, region_end, block_count, page_addr,
		output ready);
endinterface

interface bpfa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_addr;
	logic [1:0]  status;
	logic [15:0] free_count;
	modport source (output valid, result_addr, status, free_count, input ready);
	modport sink (input valid, result_addr, status, free_count, output ready);
endinterface

interface bpfa_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// ----- src/bpfa_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- src/bpfa_ctrl.sv -----
// Controller state machine: sequences each request through the datapath.
// Depends on bpfa_pkg.
module bpfa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	input  bpfa_pkg::dp_stat_t stat,
	output bpfa_pkg::dp_cmd_t  cmd
);
	import bpfa_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_DECODE  = 14'b00000000000010,
		S_ADD     = 14'b00000000000100,
		S_SPLIT   = 14'b00000000001000,
		S_NUM     = 14'b00000000010000,
		S_CLEAR   = 14'b00000000100000,
		S_SCAN_RD = 14'b00000001000000,
		S_SCAN    = 14'b00000010000000,
		S_BIT     = 14'b00000100000000,
		S_MAP     = 14'b00001000000000,
		S_MARK_RD = 14'b00010000000000,
		S_MARK_WR = 14'b00100000000000,
		S_SET_WR  = 14'b01000000000000,
		S_RESP    = 14'b10000000000000
	} state_t;

	state_t state_q, state_n;
	logic   is_alloc;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_RESP);
	assign is_alloc  = (stat.opc == OPC_ALLOC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n      = state_q;
		cmd.op       = OP_NONE;
		cmd.res_en   = 1'b0;
		cmd.res_code = ST_DONE;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_n = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.opc)
					OPC_ADD: begin
						if (stat.add_empty) begin
							cmd.res_en = 1'b1; cmd.res_code = ST_IGNORE; state_n = S_RESP;
						end else begin
							state_n = S_ADD;
						end
					end
					OPC_FIN: state_n = S_SPLIT;
					OPC_ALLOC: begin
						if (stat.alloc_bad) begin
							cmd.res_en = 1'b1; cmd.res_code = ST_REJECT; state_n = S_RESP;
						end else begin
							state_n = S_SCAN_RD;
						end
					end
					OPC_MARK, OPC_FREE: begin
						if (stat.set_bad) begin
							cmd.res_en = 1'b1; cmd.res_code = ST_IGNORE; state_n = S_RESP;
						end else begin
							state_n = S_MAP;
						end
					end
					default: begin
						cmd.res_en = 1'b1; cmd.res_code = ST_IGNORE; state_n = S_RESP;
					end
				endcase
			end
			S_ADD: begin
				priority if (stat.walk_end) begin
					cmd.res_en = 1'b1;
					state_n    = S_RESP;
					if (stat.full) begin
						cmd.res_code = ST_REJECT;
					end else begin
						cmd.op = OP_ADD_PUT;
					end
				end else if (stat.overlap) begin
					cmd.res_en = 1'b1; cmd.res_code = ST_REJECT; state_n = S_RESP;
				end else begin
					cmd.op = OP_WALK;
				end
			end
			S_SPLIT: begin
				if (stat.walk_end) begin
					cmd.op  = OP_NUM_INIT;
					state_n = S_NUM;
				end else begin
					cmd.op = OP_SPLIT;
				end
			end
			S_NUM: begin
				if (stat.walk_end) begin
					state_n = S_CLEAR;
				end else begin
					cmd.op = OP_NUM;
				end
			end
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.word_last) begin
					cmd.res_en = 1'b1; state_n = S_RESP;
				end
			end
			S_SCAN_RD: begin
				cmd.op  = OP_SCAN_RD;
				state_n = S_SCAN;
			end
			S_SCAN: begin
				cmd.op = OP_SCAN;
				priority if (stat.w_zero && stat.hit32) begin
					state_n = S_MAP;
				end else if (stat.w_zero || stat.w_ones) begin
					if (stat.word_last) begin
						cmd.res_en = 1'b1; cmd.res_code = ST_REJECT; state_n = S_RESP;
					end else begin
						state_n = S_SCAN_RD;
					end
				end else begin
					state_n = S_BIT;
				end
			end
			S_BIT: begin
				cmd.op = OP_BIT;
				priority if (stat.bit_hit) begin
					state_n = S_MAP;
				end else if (stat.bit_last) begin
					if (stat.word_last) begin
						cmd.res_en = 1'b1; cmd.res_code = ST_REJECT; state_n = S_RESP;
					end else begin
						state_n = S_SCAN_RD;
					end
				end else begin
					state_n = S_BIT;
				end
			end
			S_MAP: begin
				cmd.op = OP_MAP;
				priority if (stat.walk_end) begin
					cmd.res_en   = 1'b1;
					cmd.res_code = is_alloc ? ST_REJECT : ST_IGNORE;
					state_n      = S_RESP;
				end else if (stat.map_hit) begin
					if (is_alloc || stat.k_ok) begin
						state_n = S_MARK_RD;
					end else begin
						cmd.res_en = 1'b1; cmd.res_code = ST_IGNORE; state_n = S_RESP;
					end
				end else begin
					state_n = S_MAP;
				end
			end
			S_MARK_RD: begin
				cmd.op  = OP_MARK_RD;
				state_n = is_alloc ? S_MARK_WR : S_SET_WR;
			end
			S_MARK_WR: begin
				cmd.op = OP_MARK_WR;
				if (stat.mark_last) begin
					cmd.res_en = 1'b1; state_n = S_RESP;
				end else begin
					state_n = S_MARK_RD;
				end
			end
			S_SET_WR: begin
				cmd.op       = OP_SET_WR;
				cmd.res_en   = 1'b1;
				cmd.res_code = stat.same ? ST_IGNORE : ST_DONE;
				state_n      = S_RESP;
			end
			S_RESP: begin
				if (rsp_ready) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end
endmodule

// ----- src/bpfa_dp.sv -----
// Datapath: region table, counters, bitmap RAM and result registers.
// Depends on bpfa_pkg and bpfa_ram.
module bpfa_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpfa_pkg::req_t        req,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_wdata,
	input  bpfa_pkg::dp_cmd_t     cmd,
	output bpfa_pkg::dp_stat_t    stat,
	output logic [31:0]           result_addr,
	output logic [1:0]            status,
	output logic [15:0]           free_count
);
	import bpfa_pkg::*;

	logic [PAGE_NUM_W-1:0] rs_q [MAX_REGIONS];
	logic [PAGE_NUM_W-1:0] re_q [MAX_REGIONS];
	logic [CNT_W-1:0]      rf_q [MAX_REGIONS];
	logic [RCNT_W-1:0]     rcnt_q, idx_q;
	logic [CNT_W-1:0]      total_q, used_q, run_q;
	logic                  ready_q;
	logic [31:0]           kstart_q, kend_q, addr_q;
	req_t                  req_q;
	status_t               status_q;
	logic [WORD_AW-1:0]    word_q;
	logic [BIT_W-1:0]      bit_q;
	logic [PIDX_W-1:0]     start_q, k_q;

	logic [REG_IDX_W-1:0]  ri;
	logic [PAGE_NUM_W-1:0] cur_s, cur_e, cur_len, ep, spc, ks, p;
	logic [CNT_W-1:0]      cur_f, off, last, cnt;
	logic [32:0]           sp_w, ke_w;
	logic [PAGE_NUM_W:0]   sp, ke, sum, k;
	logic [CNT_W-1:0]      total_n;
	logic [31:0]           rdata, wdata, clr_mask, mark_mask, bit_mask;
	logic [PIDX_W-1:0]     wbase, cur_idx, start_w, start_b;
	logic [BIT_W-1:0]      lo, hi;
	logic                  we, re, inter, want, a_hit, s_hit, is_alloc;

	assign ri       = idx_q[REG_IDX_W-1:0];
	assign cur_s    = rs_q[ri];
	assign cur_e    = re_q[ri];
	assign cur_f    = rf_q[ri];
	assign cur_len  = cur_e - cur_s;
	assign cnt      = req_q.block_count;
	assign is_alloc = (opcode_t'(req_q.opcode) == OPC_ALLOC);

	// add region rounding
	assign sp_w = {1'b0, req_q.region_start} + 33'((1 << PAGE_SHIFT) - 1);
	assign sp   = sp_w[32:PAGE_SHIFT];
	assign ep   = req_q.region_end[31:PAGE_SHIFT];
	assign spc  = (sp < {1'b0, LOW_PAGE}) ? LOW_PAGE : sp[PAGE_NUM_W-1:0];

	// kernel image page bounds
	assign ks    = kstart_q[31:PAGE_SHIFT];
	assign ke_w  = {1'b0, kend_q} + 33'((1 << PAGE_SHIFT) - 1);
	assign ke    = ke_w[32:PAGE_SHIFT];
	assign inter = (ks < cur_e) && (ke > {1'b0, cur_s});

	assign sum     = {5'b0, total_q} + {1'b0, cur_len};
	assign total_n = (sum > {5'b0, MAX_PAGES}) ? MAX_PAGES : sum[CNT_W-1:0];

	assign wbase    = {word_q, {BIT_W{1'b0}}};
	assign cur_idx  = {word_q, bit_q};
	assign start_w  = (run_q == '0) ? wbase : start_q;
	assign start_b  = (run_q == '0) ? cur_idx : start_q;
	// tail pages beyond the numbered total read as used
	always_comb begin
		priority if ({1'b0, total_q} >= {2'b0, wbase} + 17'd32) begin
			clr_mask = '0;
		end else if (total_q <= {1'b0, wbase}) begin
			clr_mask = '1;
		end else begin
			clr_mask = 32'hFFFF_FFFF << total_q[BIT_W-1:0];
		end
	end

	// index/address lookup for the region under the walk pointer
	assign off   = {1'b0, start_q} - cur_f;
	assign a_hit = ({1'b0, start_q} >= cur_f) && ({4'b0, off} < cur_len);
	assign p     = req_q.page_addr[31:PAGE_SHIFT];
	assign s_hit = (p >= cur_s) && (p < cur_e);
	assign k     = {5'b0, cur_f} + {1'b0, p - cur_s};

	assign last      = {1'b0, start_q} + cnt - 16'd1;
	assign lo        = (word_q == start_q[PIDX_W-1:BIT_W]) ? start_q[BIT_W-1:0] : '0;
	assign hi        = (word_q == last[PIDX_W-1:BIT_W]) ? last[BIT_W-1:0] : '1;
	assign mark_mask = (32'hFFFF_FFFF << lo) & (32'hFFFF_FFFF >> (5'd31 - hi));
	assign bit_mask  = 32'd1 << k_q[BIT_W-1:0];
	assign want      = (opcode_t'(req_q.opcode) == OPC_MARK);

	always_comb begin
		stat.opc       = opcode_t'(req_q.opcode);
		stat.walk_end  = (idx_q >= rcnt_q);
		stat.add_empty = ready_q || (sp >= {1'b0, ep}) || (ep <= LOW_PAGE);
		stat.overlap   = (spc < cur_e) && (ep > cur_s);
		stat.full      = (rcnt_q >= RCNT_W'(MAX_REGIONS));
		stat.w_zero    = (rdata == '0);
		stat.w_ones    = (rdata == '1);
		stat.hit32     = ({1'b0, run_q} + 17'd32) >= {1'b0, cnt};
		stat.word_last = (word_q == '1);
		stat.bit_hit   = !rdata[bit_q] && (({1'b0, run_q} + 17'd1) == {1'b0, cnt});
		stat.bit_last  = (bit_q == '1);
		stat.map_hit   = is_alloc ? a_hit : s_hit;
		stat.k_ok      = (k < {5'b0, total_q});
		stat.mark_last = (word_q == last[PIDX_W-1:BIT_W]);
		stat.same      = (rdata[k_q[BIT_W-1:0]] == want);
		stat.alloc_bad = !ready_q || (cnt == '0) || (cnt > total_q);
		stat.set_bad   = !ready_q || (req_q.page_addr == '0);
	end

	always_comb begin
		re    = (cmd.op == OP_SCAN_RD) || (cmd.op == OP_MARK_RD);
		we    = 1'b0;
		wdata = clr_mask;
		unique case (cmd.op)
			OP_CLEAR: we = 1'b1;
			OP_MARK_WR: begin
				we    = 1'b1;
				wdata = rdata | mark_mask;
			end
			OP_SET_WR: begin
				we    = !stat.same;
				wdata = want ? (rdata | bit_mask) : (rdata & ~bit_mask);
			end
			default: we = 1'b0;
		endcase
	end

	bpfa_ram #(.WIDTH(32), .DEPTH(WORDS)) u_bitmap (
		.clk   (clk),
		.we    (we),
		.waddr (word_q),
		.wdata (wdata),
		.re    (re),
		.raddr (word_q),
		.rdata (rdata)
	);

	// region table: no reset, entries are written before they are read
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_ADD_PUT: begin
				if (!stat.full) begin
					rs_q[rcnt_q[REG_IDX_W-1:0]] <= spc;
					re_q[rcnt_q[REG_IDX_W-1:0]] <= ep;
					rf_q[rcnt_q[REG_IDX_W-1:0]] <= '0;
				end
			end
			OP_SPLIT: begin
				if (inter) begin
					if (cur_s < ks) begin
						re_q[ri] <= ks;
						if ((ke < {1'b0, cur_e}) && !stat.full) begin
							rs_q[rcnt_q[REG_IDX_W-1:0]] <= ke[PAGE_NUM_W-1:0];
							re_q[rcnt_q[REG_IDX_W-1:0]] <= cur_e;
							rf_q[rcnt_q[REG_IDX_W-1:0]] <= '0;
						end
					end else begin
						rs_q[ri] <= (ke < {1'b0, cur_e}) ? ke[PAGE_NUM_W-1:0] : cur_e;
					end
				end
			end
			OP_NUM: rf_q[ri] <= total_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				req_q   <= req;
				idx_q   <= '0;
				word_q  <= '0;
				bit_q   <= '0;
				run_q   <= '0;
				start_q <= '0;
				addr_q  <= '0;
			end
			OP_WALK, OP_SPLIT, OP_NUM: idx_q <= idx_q + 6'd1;
			OP_NUM_INIT: begin
				idx_q  <= '0;
				word_q <= '0;
			end
			OP_CLEAR: word_q <= word_q + 10'd1;
			OP_SCAN: begin
				bit_q <= '0;
				if (stat.w_zero) begin
					run_q   <= run_q + 16'd32;
					start_q <= start_w;
					word_q  <= word_q + 10'd1;
				end else if (stat.w_ones) begin
					run_q  <= '0;
					word_q <= word_q + 10'd1;
				end
			end
			OP_BIT: begin
				bit_q <= bit_q + 5'd1;
				if (rdata[bit_q]) begin
					run_q <= '0;
				end else begin
					run_q   <= run_q + 16'd1;
					start_q <= start_b;
				end
				if (stat.bit_last) begin
					word_q <= word_q + 10'd1;
				end
			end
			OP_MAP: begin
				if (stat.map_hit) begin
					if (is_alloc) begin
						addr_q <= {cur_s + PAGE_NUM_W'(off), {PAGE_SHIFT{1'b0}}};
						word_q <= start_q[PIDX_W-1:BIT_W];
					end else begin
						k_q    <= k[PIDX_W-1:0];
						word_q <= k[PIDX_W-1:BIT_W];
					end
				end else begin
					idx_q <= idx_q + 6'd1;
				end
			end
			OP_MARK_WR: word_q <= word_q + 10'd1;
			default: ;
		endcase
		if (cmd.res_en) begin
			status_q <= cmd.res_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q   <= '0;
			total_q  <= '0;
			used_q   <= '0;
			ready_q  <= 1'b0;
			kstart_q <= KIMG_RST;
			kend_q   <= KIMG_RST;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_KSTART: kstart_q <= cfg_wdata;
					CFG_KEND:   kend_q   <= cfg_wdata;
					default: ;
				endcase
			end
			unique case (cmd.op)
				OP_ADD_PUT: rcnt_q <= rcnt_q + 6'd1;
				OP_SPLIT: begin
					if (inter && (cur_s < ks) && (ke < {1'b0, cur_e}) && !stat.full) begin
						rcnt_q <= rcnt_q + 6'd1;
					end
				end
				OP_NUM_INIT: total_q <= '0;
				OP_NUM: total_q <= total_n;
				OP_CLEAR: begin
					if (stat.word_last) begin
						used_q  <= '0;
						ready_q <= 1'b1;
					end
				end
				OP_MARK_WR: begin
					if (stat.mark_last) begin
						used_q <= used_q + cnt;
					end
				end
				OP_SET_WR: begin
					if (!stat.same) begin
						used_q <= want ? used_q + 16'd1 : used_q - 16'd1;
					end
				end
				default: ;
			endcase
		end
	end

	assign result_addr = addr_q;
	assign status      = status_q;
	assign free_count  = total_q - used_q;
endmodule

// ----- src/bitmap_page_frame_allocator_core.sv -----
// Top level of the bitmap page frame allocator.
// Depends on bpfa_pkg, the channel interfaces, bpfa_ctrl and bpfa_dp.
//
// Channels: req carries one request (opcode, region_start, region_end,
// block_count, page_addr); rsp returns one result per request (result_addr,
// status, free_count); cfg writes kernel_image_start (index 0) or
// kernel_image_end (index 1) and is always ready.
// One request is in flight at a time: req.ready is high only when idle.
// Add region and mark used / free walk the region table. Finalize walks it
// twice, splitting out the kernel image and then numbering the pages, and
// then sweeps all 1024 bitmap words clear. Allocate scans the bitmap a word
// at a time, walking the bits of a word that is neither all free nor all
// used, then walks the regions and then marks the run word by word.
// Reset empties the region table and leaves the block not finalised; the
// bitmap needs no clearing pass since finalize sweeps it.
// A result held while rsp.ready is low keeps the block busy; no further
// request is taken until it is collected.
module bitmap_page_frame_allocator_core (
	input logic        clk,
	input logic        arst_n,
	bpfa_req_if.sink   req,
	bpfa_rsp_if.source rsp,
	bpfa_cfg_if.sink   cfg
);
	import bpfa_pkg::*;

	req_t     req_pl;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign req_pl    = '{opcode: req.opcode, region_start: req.region_start,
		region_end: req.region_end, block_count: req.block_count, page_addr: req.page_addr};
	assign cfg.ready = 1'b1;

	bpfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bpfa_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_pl),
		.cfg_we      (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_wdata   (cfg.wdata),
		.cmd         (cmd),
		.stat        (stat),
		.result_addr (rsp.result_addr),
		.status      (rsp.status),
		.free_count  (rsp.free_count)
	);

	a_no_req_while_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> !rsp.valid)
		else $error("request taken while result pending");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.free_count <= MAX_PAGES))
		else $error("free count beyond capacity");

	a_addr_done: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.result_addr != '0)) |-> (rsp.status == ST_DONE))
		else $error("address returned without success");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ((rsp.status == ST_DONE) || (rsp.status == ST_REJECT)
			|| (rsp.status == ST_IGNORE)))
		else $error("bad status code");
endmodule

// ----- tb/sv/bitmap_page_frame_allocator_core_test.sv -----
`timescale 1ns / 1ps
// Testbench for bitmap_page_frame_allocator_core: a stimulus table then random phases, each result
// checked against table values or an in-bench model. Uses bpfa_pkg and the channel interfaces.
module bitmap_page_frame_allocator_core_test;
	import bpfa_pkg::*;

	localparam logic [2:0] OPC_SPARE_LO = 3'd5;
	localparam logic [2:0] OPC_SPARE_HI = 3'd7;
	localparam int unsigned PAGE = 4096;
	localparam int unsigned LOW_PG = 256;
	localparam int unsigned CAP = 32768;
	localparam int WATCHDOG_LIMIT = 200000;

	typedef struct {
		logic [2:0]  opc;
		logic [31:0] rs;
		logic [31:0] re;
		logic [15:0] bc;
		logic [31:0] pa;
		bit          typed;
		status_t     st;
		logic [31:0] addr;
	} row_t;

	typedef struct packed {
		logic [31:0] addr;
		status_t     st;
		logic [15:0] free;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bpfa_req_if req_ch();
	bpfa_rsp_if rsp_ch();
	bpfa_cfg_if cfg_ch();

	bitmap_page_frame_allocator_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// allocator model state
	int unsigned rg_start[32];
	int unsigned rg_end[32];
	int unsigned rg_first[32];
	int unsigned rg_count = 0;
	bit          page_used[CAP];
	int unsigned total_pg = 0;
	int unsigned used_pg = 0;
	bit          numbered = 1'b0;
	logic [31:0] kimg_start = KIMG_RST;
	logic [31:0] kimg_end = KIMG_RST;

	result_t due_results[$];
	row_t    plan[$];
	int      fails = 0;
	int      idle_cycles = 0;
	int      stall_left = 0;
	bit      req_steady = 1'b0;
	bit      rsp_steady = 1'b0;

	function automatic status_t add_range(logic [31:0] s, logic [31:0] e);
		longint unsigned sp, ep;
		sp = ({32'd0, s} + PAGE - 1) / PAGE;
		ep = {32'd0, e} / PAGE;
		if (numbered || sp >= ep || ep <= LOW_PG)
			return ST_IGNORE;
		if (sp < LOW_PG)
			sp = 64'(LOW_PG);
		for (int i = 0; i < rg_count; i++)
			if (sp < rg_end[i] && ep > rg_start[i])
				return ST_REJECT;
		if (rg_count >= 32)
			return ST_REJECT;
		rg_start[rg_count] = 32'(sp);
		rg_end[rg_count] = 32'(ep);
		rg_first[rg_count] = 0;
		rg_count++;
		return ST_DONE;
	endfunction

	function automatic void number_pages();
		longint unsigned ks, ke;
		int unsigned s, e;
		ks = {32'd0, kimg_start} / PAGE;
		ke = ({32'd0, kimg_end} + PAGE - 1) / PAGE;
		// carve the kernel image out; a tail that finds the table full is dropped
		for (int i = 0; i < rg_count && i < 32; i++) begin
			s = rg_start[i];
			e = rg_end[i];
			if (ks < e && ke > s) begin
				if (s < ks) begin
					rg_end[i] = 32'(ks);
					if (ke < e && rg_count < 32) begin
						rg_start[rg_count] = 32'(ke);
						rg_end[rg_count] = e;
						rg_first[rg_count] = 0;
						rg_count++;
					end
				end else begin
					rg_start[i] = (ke < e) ? 32'(ke) : e;
				end
			end
		end
		total_pg = 0;
		for (int i = 0; i < rg_count && i < 32; i++) begin
			rg_first[i] = total_pg;
			total_pg += rg_end[i] - rg_start[i];
			if (total_pg > CAP)
				total_pg = CAP;
		end
		for (int b = 0; b < CAP; b++)
			page_used[b] = (b >= total_pg);
		used_pg = 0;
		numbered = 1'b1;
	endfunction

	function automatic logic [31:0] page_index_addr(int unsigned idx);
		int unsigned f, n;
		for (int i = 0; i < rg_count && i < 32; i++) begin
			f = rg_first[i];
			n = rg_end[i] - rg_start[i];
			if (idx >= f && idx - f < n)
				return (rg_start[i] + (idx - f)) * PAGE;
		end
		return 32'd0;
	endfunction

	function automatic status_t alloc_run(int unsigned cnt, output logic [31:0] addr);
		int unsigned run, first;
		bit found;
		logic [31:0] a;
		run = 0;
		first = 0;
		found = 1'b0;
		addr = 32'd0;
		if (!numbered || cnt == 0 || cnt > total_pg)
			return ST_REJECT;
		for (int unsigned i = 0; i < total_pg; i++) begin
			if (page_used[i])
				run = 0;
			else
				run++;
			if (run == cnt) begin
				first = i + 1 - cnt;
				found = 1'b1;
				break;
			end
		end
		if (!found)
			return ST_REJECT;
		a = page_index_addr(first);
		if (a == 0)
			return ST_REJECT;
		for (int unsigned j = 0; j < cnt; j++)
			page_used[first + j] = 1'b1;
		used_pg += cnt;
		addr = a;
		return ST_DONE;
	endfunction

	function automatic status_t set_page(logic [31:0] a, bit used);
		int unsigned p, k;
		bit hit;
		p = a / PAGE;
		hit = 1'b0;
		k = 0;
		for (int i = 0; i < rg_count && i < 32; i++) begin
			if (p >= rg_start[i] && p < rg_end[i]) begin
				k = rg_first[i] + (p - rg_start[i]);
				hit = (k < total_pg);
				break;
			end
		end
		if (a == 0 || !numbered || !hit || page_used[k] == used)
			return ST_IGNORE;
		page_used[k] = used;
		if (used)
			used_pg++;
		else
			used_pg--;
		return ST_DONE;
	endfunction

	function automatic result_t allocator_predict(row_t r);
		result_t res;
		res.addr = 32'd0;
		case (r.opc)
			OPC_ADD:   res.st = add_range(r.rs, r.re);
			OPC_FIN: begin
				number_pages();
				res.st = ST_DONE;
			end
			OPC_ALLOC: res.st = alloc_run(r.bc, res.addr);
			OPC_MARK:  res.st = set_page(r.pa, 1'b1);
			OPC_FREE:  res.st = set_page(r.pa, 1'b0);
			default:   res.st = ST_IGNORE;
		endcase
		res.free = 16'(total_pg - used_pg);
		return res;
	endfunction

	function automatic void plan_row(logic [2:0] opc, logic [31:0] rs, logic [31:0] re,
			logic [15:0] bc, logic [31:0] pa, bit typed, status_t st, logic [31:0] addr);
		row_t r;
		r.opc = opc;
		r.rs = rs;
		r.re = re;
		r.bc = bc;
		r.pa = pa;
		r.typed = typed;
		r.st = st;
		r.addr = addr;
		plan.push_back(r);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (req_steady || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pick_addr();
		int unsigned i, r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 32'd0;
		if (r < 3 || rg_count == 0)
			return $urandom;
		i = $urandom_range(0, rg_count - 1);
		if (rg_end[i] <= rg_start[i])
			return rg_start[i] * PAGE;
		return (rg_start[i] + $urandom_range(0, rg_end[i] - rg_start[i] - 1)) * PAGE
			+ $urandom_range(0, PAGE - 1);
	endfunction

	task automatic send_request(row_t r);
		int gap;
		result_t res;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= r.opc;
		req_ch.region_start <= r.rs;
		req_ch.region_end <= r.re;
		req_ch.block_count <= r.bc;
		req_ch.page_addr <= r.pa;
		do @(posedge clk); while (!req_ch.ready);
		res = allocator_predict(r);
		if (r.typed) begin
			res.st = r.st;
			res.addr = r.addr;
		end
		due_results.push_back(res);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [31:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_KSTART)
			kimg_start = v;
		else
			kimg_end = v;
		@(posedge clk);
	endtask

	task automatic random_request();
		row_t r;
		int unsigned w;
		r.typed = 1'b0;
		r.st = ST_DONE;
		r.addr = 32'd0;
		r.rs = $urandom;
		r.re = $urandom;
		r.bc = 16'($urandom);
		r.pa = pick_addr();
		w = $urandom_range(0, 99);
		if (w < 30) begin
			r.opc = OPC_ALLOC;
			w = $urandom_range(0, 99);
			if (w < 70)
				r.bc = 16'($urandom_range(1, 8));
			else if (w < 85)
				r.bc = 16'($urandom_range(9, 64));
			else if (w < 90)
				r.bc = 16'd0;
			else if (w < 95)
				r.bc = 16'(total_pg + $urandom_range(1, 4));
		end else if (w < 60) begin
			r.opc = OPC_MARK;
		end else if (w < 90) begin
			r.opc = OPC_FREE;
		end else if (w < 93) begin
			r.opc = OPC_FIN;
		end else if (w < 96) begin
			r.opc = OPC_ADD;
		end else begin
			r.opc = 3'($urandom_range(OPC_SPARE_LO, OPC_SPARE_HI));
		end
		send_request(r);
	endtask

	task automatic fill_region_table();
		row_t r;
		int unsigned pg, tries;
		r.typed = 1'b0;
		r.st = ST_DONE;
		r.addr = 32'd0;
		r.opc = OPC_ADD;
		r.bc = 16'($urandom);
		r.pa = $urandom;
		tries = 0;
		// small regions, many of them overlapping, until one slot is left for the big one
		while (rg_count < 31 && tries < 400) begin
			tries++;
			if ($urandom_range(0, 7) == 0) begin
				r.rs = $urandom;
				r.re = $urandom_range(0, r.rs);
			end else begin
				pg = $urandom_range(1024, 8191);
				r.rs = pg * PAGE - $urandom_range(0, PAGE - 1);
				r.re = (pg + $urandom_range(1, 32)) * PAGE + $urandom_range(0, PAGE - 1);
			end
			send_request(r);
		end
	endtask

	// response side: stalls and checking
	always @(posedge clk) begin
		result_t exp;
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("bitmap_page_frame_allocator_core test failed");
			$finish;
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (due_results.size() == 0) begin
				$display("%0t: result with no request outstanding", $time);
				fails++;
			end else begin
				exp = due_results.pop_front();
				if (rsp_ch.result_addr !== exp.addr) begin
					$display("%0t: result_addr exp %h got %h", $time, exp.addr, rsp_ch.result_addr);
					fails++;
				end
				if (rsp_ch.status !== exp.st) begin
					$display("%0t: status exp %0d got %0d", $time, exp.st, rsp_ch.status);
					fails++;
				end
				if (rsp_ch.free_count !== exp.free) begin
					$display("%0t: free_count exp %0d got %0d", $time, exp.free,
						rsp_ch.free_count);
					fails++;
				end
			end
		end
		if (stall_left > 0) begin
			stall_left--;
		end else if (!rsp_steady && $urandom_range(0, 99) < 15) begin
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 3);
		end
		rsp_ch.ready <= (stall_left == 0);
	end

	initial begin
		int fill_at, reg_pick, n_ops;
		logic [31:0] ks, ke;
		req_ch.valid = 1'b0;
		req_ch.opcode = OPC_ADD;
		req_ch.region_start = '0;
		req_ch.region_end = '0;
		req_ch.block_count = '0;
		req_ch.page_addr = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_KSTART;
		cfg_ch.wdata = '0;

		// before finalize
		plan_row(OPC_ALLOC, 0, 0, 16'd1, 0, 1, ST_REJECT, 0);
		plan_row(OPC_MARK, 0, 0, 0, 32'h0020_0000, 1, ST_IGNORE, 0);
		plan_row(OPC_FREE, 0, 0, 0, 32'hFFFF_FFFF, 1, ST_IGNORE, 0);
		plan_row(OPC_SPARE_LO, 0, 0, 0, 0, 1, ST_IGNORE, 0);
		plan_row(OPC_SPARE_HI, '1, '1, '1, '1, 1, ST_IGNORE, 0);
		plan_row(OPC_ADD, 32'h0, 32'h0008_0000, 0, 0, 1, ST_IGNORE, 0);
		plan_row(OPC_ADD, 32'h0030_0000, 32'h0030_0000, 0, 0, 1, ST_IGNORE, 0);
		plan_row(OPC_ADD, 32'hFFFF_F001, 32'hFFFF_FFFF, 0, 0, 1, ST_IGNORE, 0);
		plan_row(OPC_ADD, 32'h0, 32'h0020_0000, 0, 0, 1, ST_DONE, 0);
		plan_row(OPC_ADD, 32'h001F_F000, 32'h0030_0000, 0, 0, 1, ST_REJECT, 0);
		fill_at = plan.size();
		plan_row(OPC_ADD, 32'h1000_0000, 32'h1A00_0000, 0, 0, 1, ST_DONE, 0);
		plan_row(OPC_ADD, 32'hF000_0000, 32'hF000_1000, 0, 0, 1, ST_REJECT, 0);
		plan_row(OPC_FIN, 0, 0, 0, 0, 0, ST_DONE, 0);
		plan_row(OPC_ADD, 32'h0500_0000, 32'h0600_0000, 0, 0, 1, ST_IGNORE, 0);
		plan_row(OPC_ALLOC, 0, 0, 16'd0, 0, 1, ST_REJECT, 0);
		plan_row(OPC_ALLOC, 0, 0, 16'hFFFF, 0, 1, ST_REJECT, 0);
		plan_row(OPC_ALLOC, 0, 0, 16'd32768, 0, 0, ST_DONE, 0);
		plan_row(OPC_MARK, 0, 0, 0, 32'h0, 1, ST_IGNORE, 0);
		plan_row(OPC_FREE, 0, 0, 0, 32'h0010_0000, 0, ST_DONE, 0);
		plan_row(OPC_FREE, 0, 0, 0, 32'h0010_0ABC, 0, ST_DONE, 0);
		plan_row(OPC_MARK, 0, 0, 0, 32'h0010_0000, 0, ST_DONE, 0);
		// last pages of the big region lie past capacity
		plan_row(OPC_MARK, 0, 0, 0, 32'h19FF_F000, 1, ST_IGNORE, 0);
		plan_row(OPC_FREE, 0, 0, 0, 32'h000F_F000, 1, ST_IGNORE, 0);
		plan_row(OPC_ALLOC, 0, 0, 16'd1, 0, 0, ST_DONE, 0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < plan.size(); i++) begin
			if (i == fill_at)
				fill_region_table();
			send_request(plan[i]);
		end

		for (int ph = 0; ph < 8; ph++) begin
			drain();
			req_steady = (ph % 3 == 1);
			rsp_steady = (ph % 3 == 2);
			case (ph)
				0: begin
					ks = KIMG_RST;
					ke = KIMG_RST;
				end
				1: begin
					ks = 32'hFFFF_FFFF;
					ke = 32'h0;
				end
				6: begin
					ks = $urandom;
					ke = ks + $urandom_range(0, 32'h0010_0000);
				end
				7: begin
					ks = 32'h0;
					ke = 32'hFFFF_FFFF;
				end
				default: begin
					reg_pick = (ph == 5) ? 31 : $urandom_range(1, 30);
					ks = rg_start[reg_pick] * PAGE
						+ $urandom_range(0, (rg_end[reg_pick] - rg_start[reg_pick]) * PAGE);
					ke = ks + $urandom_range(1, 32'h0002_0000);
				end
			endcase
			if (ph % 2 == 0) begin
				write_reg(CFG_KSTART, ks);
				write_reg(CFG_KEND, ke);
			end else begin
				write_reg(CFG_KEND, ke);
				write_reg(CFG_KSTART, ks);
			end
			plan_row(OPC_FIN, 0, 0, 0, 0, 0, ST_DONE, 0);
			send_request(plan[plan.size() - 1]);
			n_ops = (ph == 7) ? 20 : 70;
			repeat (n_ops) random_request();
		end

		drain();
		repeat (40) @(posedge clk);
		if (fails == 0)
			$display("bitmap_page_frame_allocator_core test passed");
		else
			$display("bitmap_page_frame_allocator_core test failed");
		$finish;
	end

endmodule
